FILE: hw/rtl/lgc_pkg.sv
// lgc_pkg: shared constants, command types and coefficient tables for the
// loudness gain controller; used by lgc_mul, lgc_div and the top level

package lgc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int WIN_DEPTH = 64;
   localparam int WIN_AW = 6;
   localparam int PW_BITS = 48;
   localparam int MAX_BLOCK_SAMPLES = 32768;

   localparam logic [2:0] REG_RATE_SELECT = 3'd0;
   localparam logic [2:0] REG_TARGET_LOUDNESS = 3'd1;
   localparam logic [2:0] REG_MAX_STEP = 3'd2;
   localparam logic [2:0] REG_BYPASS = 3'd3;
   localparam logic [2:0] REG_BLOCK_LENGTH = 3'd4;
   localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd5;
   localparam logic [2:0] REG_WINDOW_BLOCKS = 3'd6;

   localparam logic [1:0] RATE_48K = 2'd0;
   localparam logic [1:0] RATE_44K = 2'd1;

   typedef struct packed {
      logic start;
      logic accum;
      logic signed [33:0] mcand;
      logic [31:0] mplier;
      logic [5:0] nbits;
      logic b_signed;
   } mul_cmd_type;

   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [16:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // biquad coefficients in Q3.28, taps b0 b1 b2 a1 a2
   function automatic logic signed [31:0] coef(input logic [1:0] sel, input logic stage,
                                               input logic [2:0] k);
      logic signed [31:0] c;
      c = '0;
      if (sel == RATE_48K) begin
         case ({stage, k})
            4'b0000: c = 32'sd412081942;
            4'b0001: c = -32'sd722546694;
            4'b0010: c = 32'sd321691121;
            4'b0011: c = -32'sd453832898;
            4'b0100: c = 32'sd196623811;
            4'b1000: c = 32'sd268435456;
            4'b1001: c = -32'sd536870912;
            4'b1010: c = 32'sd268435456;
            4'b1011: c = -32'sd534199296;
            4'b1100: c = 32'sd265770496;
            default: c = '0;
         endcase
      end else if (sel == RATE_44K) begin
         case ({stage, k})
            4'b0000: c = 32'sd410932064;
            4'b0001: c = -32'sd711617024;
            4'b0010: c = 32'sd313822276;
            4'b0011: c = -32'sd446584019;
            4'b0100: c = 32'sd191285879;
            4'b1000: c = 32'sd268435456;
            4'b1001: c = -32'sd536870912;
            4'b1010: c = 32'sd268435456;
            4'b1011: c = -32'sd533963668;
            4'b1100: c = 32'sd265536094;
            default: c = '0;
         endcase
      end else begin
         c = (k == 3'd0) ? 32'sd268435456 : 32'sd0;
      end
      return c;
   endfunction

   // constant terms of the cubic 2^f approximation, Horner order
   function automatic logic [17:0] horner_c(input logic [2:0] k);
      logic [17:0] c;
      case (k)
         3'd0: c = 18'd14824;
         3'd1: c = 18'd45587;
         default: c = 18'd65536;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/lgc_ram.sv
// lgc_ram: generic single write port, single read port memory with
// registered read data; no dependencies

module lgc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/lgc_mul.sv
// lgc_mul: bit-serial shift-add multiply-accumulate unit, one multiplier bit
// per cycle; depends on lgc_pkg

module lgc_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  lgc_pkg::mul_cmd_type      cmd,
   output lgc_pkg::unit_status_type  status,
   output logic signed [67:0]        acc
);

   logic busy_ff, done_ff, sgn_ff;
   logic [5:0] cnt_ff;
   logic signed [67:0] mcand_ff, acc_ff;
   logic [31:0] mplier_ff;
   logic signed [67:0] addend;

   always_comb begin
      if (!mplier_ff[0]) begin
         addend = '0;
      end else if (sgn_ff && cnt_ff == 6'd1) begin
         addend = -mcand_ff;
      end else begin
         addend = mcand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (cmd.start) begin
         mcand_ff <= 68'(cmd.mcand);
         acc_ff <= cmd.accum ? acc_ff : '0;
         mplier_ff <= cmd.mplier;
         cnt_ff <= cmd.nbits;
         sgn_ff <= cmd.b_signed;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + addend;
         mcand_ff <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign acc = acc_ff;

endmodule

FILE: hw/rtl/lgc_div.sv
// lgc_div: restoring divider, one quotient bit per cycle, 64-bit dividend
// and 17-bit divisor; depends on lgc_pkg

module lgc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  lgc_pkg::div_cmd_type      cmd,
   output lgc_pkg::unit_status_type  status,
   output logic [63:0]               quotient
);

   logic busy_ff, done_ff;
   logic [6:0] cnt_ff;
   logic [63:0] quo_ff;
   logic [16:0] rem_ff, dvs_ff;
   logic [17:0] trial;
   logic fits;

   assign trial = {rem_ff, quo_ff[63]};
   assign fits = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 7'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (cmd.start) begin
         quo_ff <= cmd.dividend;
         rem_ff <= '0;
         dvs_ff <= cmd.divisor;
         cnt_ff <= 7'd64;
      end else if (busy_ff) begin
         rem_ff <= fits ? 17'(trial - {1'b0, dvs_ff}) : trial[16:0];
         quo_ff <= {quo_ff[62:0], fits};
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/loudness_gain_controller.sv
// loudness_gain_controller: top level sequencer of the stereo loudness meter
// and gain control; depends on lgc_pkg, lgc_mul, lgc_div and lgc_ram
//
// Usage: one transaction on the req channel carries a stereo sample pair;
// exactly one transaction on the rsp channel follows with both output
// samples (gained, or passed through in bypass), the gain now in force and
// the last window loudness. The csr port writes registers 0..6; the user
// must use it only while the block is idle; the block does not enforce this.
// The block works on one sample pair at a time. All products go through one
// bit-serial multiplier and all quotients through one bit-serial divider, so
// a pair costs twenty biquad taps, two squares and, unless bypassed, two
// output scalings. A measurement block end adds the block power and window
// mean divisions, normalizing, sixteen log squarings and a read for each
// block dropped; a gain update adds a division and four multiplications.
// req_ready is high while the sequencer is idle; a finished result waits in
// the output register while the next pair is already taken and worked on.
// If the receiver stalls, the sequencer holds its finished result until the
// output register frees up. Reset is synchronous: filters, energies, window,
// counters and gain clear, registers take their defaults, and the block is
// ready on the next cycle.

module loudness_gain_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_left_in,
   input  logic signed [23:0] req_right_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_left_out,
   output logic signed [23:0] rsp_right_out,
   output logic signed [13:0] rsp_gain_now,
   output logic signed [15:0] rsp_loudness_est,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_WAIT = 5'd1;
   localparam logic [4:0] S_BQ_MAC = 5'd2;
   localparam logic [4:0] S_BQ_END = 5'd3;
   localparam logic [4:0] S_SQ = 5'd4;
   localparam logic [4:0] S_ACC = 5'd5;
   localparam logic [4:0] S_BLOCK = 5'd6;
   localparam logic [4:0] S_PW = 5'd7;
   localparam logic [4:0] S_DROP = 5'd8;
   localparam logic [4:0] S_DSUB = 5'd9;
   localparam logic [4:0] S_LOUD = 5'd10;
   localparam logic [4:0] S_LNORM0 = 5'd11;
   localparam logic [4:0] S_LNORM = 5'd12;
   localparam logic [4:0] S_LSQ = 5'd13;
   localparam logic [4:0] S_LSQ2 = 5'd14;
   localparam logic [4:0] S_LMUL = 5'd15;
   localparam logic [4:0] S_LFIN = 5'd16;
   localparam logic [4:0] S_UPD = 5'd17;
   localparam logic [4:0] S_GAIN = 5'd18;
   localparam logic [4:0] S_T = 5'd19;
   localparam logic [4:0] S_T2 = 5'd20;
   localparam logic [4:0] S_HM = 5'd21;
   localparam logic [4:0] S_H = 5'd22;
   localparam logic [4:0] S_G = 5'd23;
   localparam logic [4:0] S_OUT = 5'd24;
   localparam logic [4:0] S_OSC = 5'd25;
   localparam logic [4:0] S_SCL = 5'd26;
   localparam logic [4:0] S_FIN = 5'd27;

   // configuration
   logic [1:0] rate_sel_ff;
   logic signed [15:0] target_ff;
   logic [12:0] max_step_ff;
   logic bypass_ff;
   logic [15:0] blen_cfg_ff, ivl_cfg_ff;
   logic [6:0] wblk_cfg_ff;
   logic [15:0] blen, ivl;
   logic [6:0] wmax;

   // sequencer and datapath state
   logic [4:0] state_ff, ret_ff;
   logic signed [23:0] x_ff [2];
   logic signed [23:0] out_ff [2];
   logic signed [31:0] hist_ff [16];
   logic ch_ff, stage_ff;
   logic [2:0] k_ff;
   logic signed [31:0] y_ff;
   logic [63:0] energy_ff [2];
   logic [14:0] block_count_ff;
   logic [53:0] total_ff;
   logic [6:0] fill_ff;
   logic [5:0] head_ff;
   logic [15:0] update_count_ff;
   logic signed [13:0] gain_ff;
   logic signed [15:0] loud_ff;
   logic [24:0] g_ff;
   logic [47:0] pw_ff;
   logic [53:0] norm_ff;
   logic [5:0] e_ff;
   logic [30:0] m_ff;
   logic [21:0] l2_ff;
   logic [3:0] i_ff;
   logic [17:0] p_ff;
   logic [15:0] f_ff;
   logic [2:0] sh_ff;
   logic err_neg_ff;
   logic rsp_valid_ff;
   logic signed [23:0] rsp_left_ff, rsp_right_ff;
   logic signed [13:0] rsp_gain_ff;
   logic signed [15:0] rsp_loud_ff;

   // units
   lgc_pkg::mul_cmd_type mul_cmd;
   lgc_pkg::div_cmd_type div_cmd;
   lgc_pkg::unit_status_type mul_status, div_status;
   logic signed [67:0] mul_acc;
   logic [63:0] div_quo;
   logic ram_wen;
   logic [5:0] ram_raddr;
   logic [47:0] ram_rdata;

   // combinational helpers
   logic signed [31:0] xcur, cval, hval, ysat;
   logic [3:0] hbase;
   logic signed [67:0] rnd, tr, vr;
   logic [64:0] sum_e, esum;
   logic [63:0] esat;
   logic [15:0] bc_next;
   logic [16:0] uc_next;
   logic [15:0] lq;
   logic signed [16:0] l17;
   logic signed [17:0] err;
   logic [17:0] mag;
   logic [12:0] chg;
   logic signed [15:0] gsum;
   logic signed [3:0] tn;
   logic signed [4:0] n5;
   logic signed [23:0] vsat;

   assign blen = (blen_cfg_ff == 16'd0) ? 16'd1 :
                 (blen_cfg_ff > 16'(lgc_pkg::MAX_BLOCK_SAMPLES)) ?
                 16'(lgc_pkg::MAX_BLOCK_SAMPLES) : blen_cfg_ff;
   assign ivl = (ivl_cfg_ff == 16'd0) ? 16'd1 : ivl_cfg_ff;
   assign wmax = (wblk_cfg_ff == 7'd0) ? 7'd1 :
                 (wblk_cfg_ff > 7'(lgc_pkg::WIN_DEPTH)) ? 7'(lgc_pkg::WIN_DEPTH) : wblk_cfg_ff;

   assign xcur = stage_ff ? y_ff : 32'(x_ff[ch_ff]);
   assign hbase = {ch_ff, stage_ff, 2'b00};
   assign hval = hist_ff[{ch_ff, stage_ff, 2'(k_ff - 3'd1)}];
   assign cval = lgc_pkg::coef(rate_sel_ff, stage_ff, k_ff);

   always_comb begin
      rnd = (mul_acc + 68'sd134217728) >>> 28;
      if (rnd > 68'sd2147483647) begin
         ysat = 32'sh7fffffff;
      end else if (rnd < -68'sd2147483648) begin
         ysat = 32'sh80000000;
      end else begin
         ysat = rnd[31:0];
      end
      sum_e = {1'b0, energy_ff[ch_ff]} + {19'b0, mul_acc[61:16]};
      esum = {1'b0, energy_ff[0]} + {1'b0, energy_ff[1]};
      esat = esum[64] ? '1 : esum[63:0];
      bc_next = {1'b0, block_count_ff} + 16'd1;
      uc_next = {1'b0, update_count_ff} + 17'd1;
      lq = 16'((mul_acc + 68'sd2147483648) >>> 32);
      l17 = $signed({1'b0, lq}) - 17'sd23296;
      err = 18'(target_ff) - 18'(loud_ff);
      mag = (err < 0) ? 18'(-err) + 18'd5 : 18'(err) + 18'd5;
      chg = (div_quo > {51'b0, max_step_ff}) ? max_step_ff : div_quo[12:0];
      gsum = err_neg_ff ? 16'(gain_ff) - $signed({3'b0, chg}) :
                          16'(gain_ff) + $signed({3'b0, chg});
      tr = (mul_acc + 68'sd32768) >>> 16;
      tn = tr[19:16];
      n5 = 5'(tn) + 5'sd4;
      vr = (mul_acc + 68'sd524288) >>> 20;
      if (vr > 68'sd8388607) begin
         vsat = 24'sh7fffff;
      end else if (vr < -68'sd8388608) begin
         vsat = 24'sh800000;
      end else begin
         vsat = vr[23:0];
      end
   end

   // unit commands
   always_comb begin
      mul_cmd = '0;
      div_cmd = '0;
      ram_wen = 1'b0;
      ram_raddr = 6'(head_ff - fill_ff[5:0]);
      case (state_ff)
         S_BQ_MAC: begin
            mul_cmd.start = 1'b1;
            mul_cmd.accum = (k_ff != 3'd0);
            mul_cmd.mcand = (k_ff >= 3'd3) ? -34'(cval) : 34'(cval);
            mul_cmd.mplier = (k_ff == 3'd0) ? xcur : hval;
            mul_cmd.nbits = 6'd32;
            mul_cmd.b_signed = 1'b1;
         end
         S_SQ: begin
            mul_cmd.start = 1'b1;
            mul_cmd.mcand = 34'(y_ff);
            mul_cmd.mplier = y_ff;
            mul_cmd.nbits = 6'd32;
            mul_cmd.b_signed = 1'b1;
         end
         S_BLOCK: begin
            div_cmd.start = (bc_next >= blen);
            div_cmd.dividend = esat;
            div_cmd.divisor = {blen, 1'b0};
         end
         S_DROP: begin
            ram_wen = (fill_ff < wmax);
         end
         S_LOUD: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = {10'b0, total_ff};
            div_cmd.divisor = {10'b0, fill_ff};
         end
         S_LSQ: begin
            mul_cmd.start = 1'b1;
            mul_cmd.mcand = {3'b0, m_ff};
            mul_cmd.mplier = {1'b0, m_ff};
            mul_cmd.nbits = 6'd31;
         end
         S_LMUL: begin
            mul_cmd.start = 1'b1;
            mul_cmd.mcand = 34'sd50504453;
            mul_cmd.mplier = {10'b0, l2_ff};
            mul_cmd.nbits = 6'd22;
         end
         S_UPD: begin
            div_cmd.start = (uc_next >= {1'b0, ivl}) && (fill_ff != 7'd0) &&
                            (loud_ff >= -16'sd15360);
            div_cmd.dividend = {46'b0, mag};
            div_cmd.divisor = 17'd10;
         end
         S_T: begin
            mul_cmd.start = 1'b1;
            mul_cmd.mcand = 34'(gain_ff);
            mul_cmd.mplier = 32'd2786635;
            mul_cmd.nbits = 6'd22;
         end
         S_HM: begin
            mul_cmd.start = 1'b1;
            mul_cmd.mcand = {16'b0, p_ff};
            mul_cmd.mplier = {16'b0, f_ff};
            mul_cmd.nbits = 6'd16;
         end
         S_OSC: begin
            mul_cmd.start = 1'b1;
            mul_cmd.mcand = 34'(x_ff[ch_ff]);
            mul_cmd.mplier = {7'b0, g_ff};
            mul_cmd.nbits = 6'd25;
         end
         default: begin
         end
      endcase
   end

   lgc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .status(mul_status),
      .acc   (mul_acc)
   );

   lgc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (div_cmd),
      .status  (div_status),
      .quotient(div_quo)
   );

   lgc_ram #(
      .WIDTH(lgc_pkg::PW_BITS),
      .DEPTH(lgc_pkg::WIN_DEPTH)
   ) u_window (
      .clock(clock),
      .wen  (ram_wen),
      .waddr(head_ff),
      .wdata(pw_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_sel_ff <= lgc_pkg::RATE_48K;
         target_ff <= -16'sd5888;
         max_step_ff <= 13'd77;
         bypass_ff <= 1'b0;
         blen_cfg_ff <= 16'd4800;
         ivl_cfg_ff <= 16'd4800;
         wblk_cfg_ff <= 7'd30;
      end else if (csr_write_enable) begin
         case (csr_index)
            lgc_pkg::REG_RATE_SELECT: rate_sel_ff <= csr_write_data[1:0];
            lgc_pkg::REG_TARGET_LOUDNESS: target_ff <= csr_write_data;
            lgc_pkg::REG_MAX_STEP: max_step_ff <= csr_write_data[12:0];
            lgc_pkg::REG_BYPASS: bypass_ff <= csr_write_data[0];
            lgc_pkg::REG_BLOCK_LENGTH: blen_cfg_ff <= csr_write_data;
            lgc_pkg::REG_UPDATE_INTERVAL: ivl_cfg_ff <= csr_write_data;
            lgc_pkg::REG_WINDOW_BLOCKS: wblk_cfg_ff <= csr_write_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int j = 0; j < 16; j++) begin
            hist_ff[j] <= '0;
         end
         energy_ff[0] <= '0;
         energy_ff[1] <= '0;
         block_count_ff <= '0;
         total_ff <= '0;
         fill_ff <= '0;
         head_ff <= '0;
         update_count_ff <= '0;
         gain_ff <= '0;
         loud_ff <= -16'sd32768;
         g_ff <= 25'd1048576;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff[0] <= req_left_in;
                  x_ff[1] <= req_right_in;
                  ch_ff <= 1'b0;
                  stage_ff <= 1'b0;
                  k_ff <= 3'd0;
                  state_ff <= S_BQ_MAC;
               end
            end
            S_WAIT: begin
               if (mul_status.done || div_status.done) begin
                  state_ff <= ret_ff;
               end
            end
            S_BQ_MAC: begin
               k_ff <= k_ff + 3'd1;
               ret_ff <= (k_ff == 3'd4) ? S_BQ_END : S_BQ_MAC;
               state_ff <= S_WAIT;
            end
            S_BQ_END: begin
               hist_ff[hbase + 4'd1] <= hist_ff[hbase];
               hist_ff[hbase] <= xcur;
               hist_ff[hbase + 4'd3] <= hist_ff[hbase + 4'd2];
               hist_ff[hbase + 4'd2] <= ysat;
               y_ff <= ysat;
               k_ff <= 3'd0;
               if (!stage_ff) begin
                  stage_ff <= 1'b1;
                  state_ff <= S_BQ_MAC;
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               ret_ff <= S_ACC;
               state_ff <= S_WAIT;
            end
            S_ACC: begin
               energy_ff[ch_ff] <= sum_e[64] ? '1 : sum_e[63:0];
               if (!ch_ff) begin
                  ch_ff <= 1'b1;
                  stage_ff <= 1'b0;
                  state_ff <= S_BQ_MAC;
               end else begin
                  state_ff <= S_BLOCK;
               end
            end
            S_BLOCK: begin
               if (bc_next >= blen) begin
                  ret_ff <= S_PW;
                  state_ff <= S_WAIT;
               end else begin
                  block_count_ff <= bc_next[14:0];
                  state_ff <= S_UPD;
               end
            end
            S_PW: begin
               pw_ff <= (div_quo[63:48] != 16'd0) ? '1 : div_quo[47:0];
               energy_ff[0] <= '0;
               energy_ff[1] <= '0;
               block_count_ff <= '0;
               state_ff <= S_DROP;
            end
            S_DROP: begin
               if (fill_ff >= wmax) begin
                  state_ff <= S_DSUB;
               end else begin
                  head_ff <= head_ff + 6'd1;
                  fill_ff <= fill_ff + 7'd1;
                  total_ff <= total_ff + {6'b0, pw_ff};
                  state_ff <= S_LOUD;
               end
            end
            S_DSUB: begin
               total_ff <= total_ff - {6'b0, ram_rdata};
               fill_ff <= fill_ff - 7'd1;
               state_ff <= S_DROP;
            end
            S_LOUD: begin
               ret_ff <= S_LNORM0;
               state_ff <= S_WAIT;
            end
            S_LNORM0: begin
               if (div_quo == 64'd0) begin
                  loud_ff <= -16'sd32768;
                  state_ff <= S_UPD;
               end else begin
                  norm_ff <= div_quo[53:0];
                  e_ff <= 6'd53;
                  state_ff <= S_LNORM;
               end
            end
            S_LNORM: begin
               if (norm_ff[53]) begin
                  m_ff <= norm_ff[53:23];
                  l2_ff <= {e_ff, 16'b0};
                  i_ff <= 4'd0;
                  state_ff <= S_LSQ;
               end else begin
                  norm_ff <= norm_ff << 1;
                  e_ff <= e_ff - 6'd1;
               end
            end
            S_LSQ: begin
               ret_ff <= S_LSQ2;
               state_ff <= S_WAIT;
            end
            S_LSQ2: begin
               if (mul_acc[61]) begin
                  m_ff <= mul_acc[61:31];
                  l2_ff <= l2_ff + (22'd1 << (4'd15 - i_ff));
               end else begin
                  m_ff <= mul_acc[60:30];
               end
               i_ff <= i_ff + 4'd1;
               state_ff <= (i_ff == 4'd15) ? S_LMUL : S_LSQ;
            end
            S_LMUL: begin
               ret_ff <= S_LFIN;
               state_ff <= S_WAIT;
            end
            S_LFIN: begin
               loud_ff <= (l17 > 17'sd2048) ? 16'sd2048 : l17[15:0];
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (uc_next >= {1'b0, ivl}) begin
                  update_count_ff <= '0;
                  if (fill_ff != 7'd0 && loud_ff >= -16'sd15360) begin
                     err_neg_ff <= (err < 0);
                     ret_ff <= S_GAIN;
                     state_ff <= S_WAIT;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else begin
                  update_count_ff <= uc_next[15:0];
                  state_ff <= S_OUT;
               end
            end
            S_GAIN: begin
               if (gsum > 16'sd5120) begin
                  gain_ff <= 14'sd5120;
               end else if (gsum < -16'sd5120) begin
                  gain_ff <= -14'sd5120;
               end else begin
                  gain_ff <= gsum[13:0];
               end
               state_ff <= S_T;
            end
            S_T: begin
               ret_ff <= S_T2;
               state_ff <= S_WAIT;
            end
            S_T2: begin
               f_ff <= tr[15:0];
               if (n5 < 0) begin
                  sh_ff <= 3'd0;
               end else if (n5 > 5'sd7) begin
                  sh_ff <= 3'd7;
               end else begin
                  sh_ff <= n5[2:0];
               end
               p_ff <= 18'd5125;
               k_ff <= 3'd0;
               state_ff <= S_HM;
            end
            S_HM: begin
               ret_ff <= S_H;
               state_ff <= S_WAIT;
            end
            S_H: begin
               p_ff <= lgc_pkg::horner_c(k_ff) + mul_acc[33:16];
               k_ff <= k_ff + 3'd1;
               state_ff <= (k_ff == 3'd2) ? S_G : S_HM;
            end
            S_G: begin
               g_ff <= 25'(p_ff) << sh_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (bypass_ff) begin
                  out_ff[0] <= x_ff[0];
                  out_ff[1] <= x_ff[1];
                  state_ff <= S_FIN;
               end else begin
                  ch_ff <= 1'b0;
                  state_ff <= S_OSC;
               end
            end
            S_OSC: begin
               ret_ff <= S_SCL;
               state_ff <= S_WAIT;
            end
            S_SCL: begin
               out_ff[ch_ff] <= vsat;
               ch_ff <= 1'b1;
               state_ff <= ch_ff ? S_FIN : S_OSC;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff <= out_ff[0];
                  rsp_right_ff <= out_ff[1];
                  rsp_gain_ff <= gain_ff;
                  rsp_loud_ff <= loud_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_gain_now = rsp_gain_ff;
   assign rsp_loudness_est = rsp_loud_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_status.busy && div_status.busy))
      else $error("multiplier and divider busy together");

   a_accept_units_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!mul_status.busy && !div_status.busy))
      else $error("transaction accepted while a unit is busy");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (gain_ff <= 14'sd5120) && (gain_ff >= -14'sd5120))
      else $error("gain out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'(lgc_pkg::WIN_DEPTH))
      else $error("window fill beyond depth");

endmodule
